@@ hw/rtl/pgw_pkg.sv @@
package pgw_pkg;

   localparam int VA_W     = 48;
   localparam int PA_W     = 52;
   localparam int FLAG_W   = 12;
   localparam int FRAME_W  = 40;
   localparam int VPN_W    = 36;
   localparam int IDX_W    = 9;
   localparam int ENTRY_W  = 64;
   localparam int USED_W   = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_MAP       = 2'd0;
   localparam logic [OP_W-1:0] OP_UNMAP     = 2'd1;
   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP       = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_MAPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_TABLES  = 2'd2;

   localparam logic [1:0] LEVEL_ROOT     = 2'd0;
   localparam logic [1:0] LEVEL_LAST_DIR = 2'd2;
   localparam logic [1:0] LEVEL_LEAF     = 2'd3;

   localparam logic [FLAG_W-1:0] PRESENT_FLAG = 12'h001;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_ALLOC,
      S_WRITE,
      S_DONE
   } walk_state_type;

endpackage

@@ hw/rtl/pgw_intf.sv @@
interface pgw_req_if import pgw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [VA_W-1:0]   virt_addr;
   logic [PA_W-1:0]   phys_addr;
   logic [FLAG_W-1:0] page_flags;

   modport source (output valid, output operation, output virt_addr, output phys_addr,
                   output page_flags, input ready);
   modport sink (input valid, input operation, input virt_addr, input phys_addr,
                 input page_flags, output ready);
endinterface

interface pgw_rsp_if import pgw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PA_W-1:0]     result_phys;
   logic [STATUS_W-1:0] status;
   logic [USED_W-1:0]   tables_used;

   modport source (output valid, output result_phys, output status, output tables_used,
                   input ready);
   modport sink (input valid, input result_phys, input status, input tables_used,
                 output ready);
endinterface

@@ hw/rtl/four_level_page_table_walker.sv @@
// Four-level page table walker over a local table store. The store holds STORE_PAGES
// tables of 512 64-bit entries in one single-port-read RAM; page 0 is the root. A request
// maps, unmaps or translates one 4 KiB page of a 48-bit virtual address; intermediate
// tables come from a bump allocator and are never reused. Table pointers in entries read
// pool_base plus page times 4096 (csr_wr_data, low 12 bits ignored; write it only while
// idle). After reset the block sweeps the whole store to zero, one entry a cycle, and
// requests are held off until then. A request is taken in S_IDLE; each table level is
// then read in S_READ (address) and S_CHECK (registered data), since each level's entry
// gives the next level's page: translate and unmap read four levels, map reads up to
// three and then checks the pool in S_ALLOC and writes one table entry per level in
// S_WRITE (one to four entries). The result then passes from S_DONE to the output
// register once the response slot is free; a no-op goes straight to S_DONE. A walk that
// stops at an absent or stray entry, or a map that finds the pool short, ends sooner.
// The next request is taken while the last response still waits on rsp_port.ready.
module four_level_page_table_walker import pgw_pkg::*; #(
   parameter int STORE_PAGES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [PA_W-1:0] csr_wr_data,
   pgw_req_if.sink         req_port,
   pgw_rsp_if.source       rsp_port
);

   localparam int PAGE_IDX_W = $clog2(STORE_PAGES);
   localparam int PAGE_W     = $clog2(STORE_PAGES + 1);
   localparam int ADDR_W     = PAGE_IDX_W + IDX_W;
   localparam int DEPTH      = STORE_PAGES * (2 ** IDX_W);
   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [PAGE_W-1:0] PAGE_TOTAL = PAGE_W'(STORE_PAGES);
   localparam logic [PAGE_W-1:0] PAGE_ONE   = PAGE_W'(1);

   walk_state_type state_ff, state_in;

   logic [1:0]            level_ff, level_in;
   logic [PAGE_IDX_W-1:0] page_ff, page_in;
   logic [PAGE_W-1:0]     next_free_ff, next_free_in;
   logic [USED_W-1:0]     alloc_ff, alloc_in;
   logic [FRAME_W-1:0]    pool_frame_ff, pool_frame_in;
   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [VPN_W-1:0]      vpn_ff, vpn_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic [FLAG_W-1:0]     flags_ff, flags_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [FRAME_W-1:0]    result_ff, result_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]       rsp_phys_ff, rsp_phys_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [USED_W-1:0]     rsp_used_ff, rsp_used_in;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]    ram_rd_data;

   logic                  req_accept;
   logic                  rsp_slot_free;
   logic [IDX_W-1:0]      tbl_idx;
   logic                  entry_present;
   logic [FRAME_W-1:0]    entry_off;
   logic                  entry_ok;
   logic [1:0]            need_tables;
   logic [PAGE_W-1:0]     free_tables;
   logic                  pool_short;
   logic [FRAME_W-1:0]    new_ptr;

   pgw_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_port.ready       = (state_ff == S_IDLE);
   assign req_accept           = req_port.valid && req_port.ready;
   assign rsp_slot_free        = !rsp_valid_ff || rsp_port.ready;

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.result_phys = rsp_phys_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.tables_used = rsp_used_ff;

   // Index slice of the virtual page number for the current level.
   always_comb begin
      case (level_ff)
         2'd0:    tbl_idx = vpn_ff[35:27];
         2'd1:    tbl_idx = vpn_ff[26:18];
         2'd2:    tbl_idx = vpn_ff[17:9];
         default: tbl_idx = vpn_ff[8:0];
      endcase
   end

   // Turn a fetched pointer back into a store page; a pointer outside the
   // allocated pages is stray and never followed.
   assign entry_present = ram_rd_data[0];
   assign entry_off     = ram_rd_data[PA_W-1:FLAG_W] - pool_frame_ff;
   assign entry_ok      = entry_off < FRAME_W'(next_free_ff);

   assign need_tables = LEVEL_LEAF - level_ff;
   assign free_tables = PAGE_TOTAL - next_free_ff;
   assign pool_short  = PAGE_W'(need_tables) > free_tables;
   assign new_ptr     = pool_frame_ff + FRAME_W'(next_free_ff[PAGE_IDX_W-1:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == CLEAR_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_port.operation == OP_NOP) ? S_DONE : S_READ;
            end
         end
         S_READ: state_in = S_CHECK;
         S_CHECK: begin
            if (level_ff == LEVEL_LEAF) begin
               state_in = S_DONE;
            end else if (!entry_present) begin
               state_in = (op_ff == OP_MAP) ? S_ALLOC : S_DONE;
            end else if (!entry_ok) begin
               state_in = S_DONE;
            end else if (level_ff == LEVEL_LAST_DIR && op_ff == OP_MAP) begin
               state_in = S_ALLOC;
            end else begin
               state_in = S_READ;
            end
         end
         S_ALLOC: state_in = pool_short ? S_DONE : S_WRITE;
         S_WRITE: begin
            if (level_ff == LEVEL_LEAF) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and store access.
   always_comb begin
      level_in      = level_ff;
      page_in       = page_ff;
      next_free_in  = next_free_ff;
      alloc_in      = alloc_ff;
      pool_frame_in = csr_wr_en ? csr_wr_data[PA_W-1:FLAG_W] : pool_frame_ff;
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      vpn_in        = vpn_ff;
      frame_in      = frame_ff;
      flags_in      = flags_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_phys_in   = rsp_phys_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = {page_ff, tbl_idx};
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = {page_ff, tbl_idx};

      case (state_ff)
         S_CLEAR: begin
            // Zero the store one entry a cycle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in     = req_port.operation;
               vpn_in    = req_port.virt_addr[VA_W-1:FLAG_W];
               frame_in  = req_port.phys_addr[PA_W-1:FLAG_W];
               flags_in  = req_port.page_flags | PRESENT_FLAG;
               level_in  = LEVEL_ROOT;
               page_in   = '0;
               status_in = STAT_OK;
               result_in = '0;
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
         end
         S_CHECK: begin
            if (level_ff == LEVEL_LEAF) begin
               if (!entry_present) begin
                  status_in = STAT_NOT_MAPPED;
               end else if (op_ff == OP_UNMAP) begin
                  ram_wr_en = 1'b1;
               end else begin
                  result_in = ram_rd_data[PA_W-1:FLAG_W];
               end
            end else if (!entry_present) begin
               // Map keeps level_ff as the first missing level.
               if (op_ff != OP_MAP) status_in = STAT_NOT_MAPPED;
            end else if (!entry_ok) begin
               status_in = STAT_NOT_MAPPED;
            end else begin
               page_in  = entry_off[PAGE_IDX_W-1:0];
               level_in = level_ff + 2'd1;
            end
         end
         S_ALLOC: begin
            if (pool_short) status_in = STAT_NO_TABLES;
         end
         S_WRITE: begin
            ram_wr_en = 1'b1;
            if (level_ff == LEVEL_LEAF) begin
               ram_wr_data = {{(ENTRY_W - PA_W){1'b0}}, frame_ff, flags_ff};
            end else begin
               // Link a fresh table and descend into it.
               ram_wr_data  = {{(ENTRY_W - PA_W){1'b0}}, new_ptr, flags_ff};
               page_in      = next_free_ff[PAGE_IDX_W-1:0];
               next_free_in = next_free_ff + PAGE_ONE;
               alloc_in     = alloc_ff + USED_W'(1);
               level_in     = level_ff + 2'd1;
            end
         end
         S_DONE: begin
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_phys_in   = {result_ff, {FLAG_W{1'b0}}};
               rsp_status_in = status_ff;
               rsp_used_in   = alloc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         next_free_ff  <= PAGE_ONE;
         alloc_ff      <= '0;
         pool_frame_ff <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         alloc_ff      <= alloc_in;
         pool_frame_ff <= pool_frame_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      page_ff       <= page_in;
      op_ff         <= op_in;
      vpn_ff        <= vpn_in;
      frame_ff      <= frame_in;
      flags_ff      <= flags_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // The allocation count tracks the bump pointer.
   a_alloc_tracks_bump: assert property (@(posedge clock) disable iff (reset)
      alloc_ff == USED_W'(next_free_ff - PAGE_ONE))
      else $error("allocation count out of step with bump pointer");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= PAGE_TOTAL)
      else $error("bump pointer ran past the store");

   // Read data is consumed only in the cycle after the read is issued.
   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHECK |-> $past(state_ff) == S_READ)
      else $error("table entry checked without a preceding read");

   // A leaf write always completes the request.
   a_leaf_write_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && level_ff == LEVEL_LEAF) |=> state_ff == S_DONE)
      else $error("leaf write did not finish the request");

   // No new request while the store is still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_port.ready && !ram_rd_en)
      else $error("store accessed during clearing pass");

endmodule

@@ hw/rtl/pgw_ram.sv @@
module pgw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
